### design/gbn_pkg.sv
`default_nettype none

package gbn_pkg;

    // Capacity of the candidate stores and derived index widths.
    localparam int MAX_CAND = 64;
    localparam int IDX_W    = $clog2(MAX_CAND);
    localparam int CNT_W    = $clog2(MAX_CAND + 1);

    // Field widths of one box.
    localparam int COORD_W = 16;
    localparam int SCORE_W = 17;
    localparam int CLASS_W = 10;
    localparam int THR_W   = 17;
    localparam int GEO_W   = 4 * COORD_W;

    localparam logic [THR_W-1:0] THR_RESET = 17'd32768;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             load_we;
        logic [IDX_W-1:0] st_waddr;
        logic             sel_order;
        logic [IDX_W-1:0] st_raddr;
        logic [IDX_W-1:0] ord_raddr;
        logic             ord_we;
        logic [IDX_W-1:0] outer_idx;
        logic             rank_clr;
        logic             rank_issue;
        logic             score_cap;
        logic             idx_cap;
        logic             cur_cap;
        logic             pair_issue;
        logic             pend_load;
        logic             push;
        logic             push_last;
        logic             push_ovf;
        logic             marks_clr;
    } gbn_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic             out_free;
        logic             pipe_busy;
        logic             cur_marked;
    } gbn_stat_t;

endpackage

`default_nettype wire

### design/gbn_datapath.sv
`default_nettype none

module gbn_datapath (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire gbn_pkg::gbn_cmd_t            cmd,
    output gbn_pkg::gbn_stat_t                stat,
    input  wire logic                         cfg_we,
    input  wire logic [gbn_pkg::THR_W-1:0]    cfg_data,
    input  wire logic [gbn_pkg::GEO_W-1:0]    in_geo,
    input  wire logic [gbn_pkg::SCORE_W-1:0]  in_score,
    input  wire logic [gbn_pkg::CLASS_W-1:0]  in_class,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [gbn_pkg::GEO_W-1:0]         out_geo,
    output logic [gbn_pkg::SCORE_W-1:0]       out_score,
    output logic [gbn_pkg::CLASS_W-1:0]       out_class,
    output logic                              out_last,
    output logic                              out_ovf
);

    localparam int IW = gbn_pkg::IDX_W;
    localparam int CW = gbn_pkg::COORD_W;

    // Candidate stores and the sorted order.
    logic [gbn_pkg::GEO_W-1:0]   geo_mem   [gbn_pkg::MAX_CAND];
    logic [gbn_pkg::SCORE_W-1:0] score_mem [gbn_pkg::MAX_CAND];
    logic [gbn_pkg::CLASS_W-1:0] class_mem [gbn_pkg::MAX_CAND];
    logic [IW-1:0]               order_mem [gbn_pkg::MAX_CAND];

    logic [gbn_pkg::GEO_W-1:0]   geo_q;
    logic [gbn_pkg::SCORE_W-1:0] score_q;
    logic [gbn_pkg::CLASS_W-1:0] class_q;
    logic [IW-1:0]               order_q;
    logic [IW-1:0]               st_raddr;

    logic [gbn_pkg::THR_W-1:0]   thr_reg;
    logic [gbn_pkg::MAX_CAND-1:0] marks_reg;

    logic [gbn_pkg::SCORE_W-1:0] si_reg;
    logic [IW-1:0]               rank_reg;
    logic                        rv1_reg;
    logic [IW-1:0]               jd_reg;

    logic [IW-1:0]               cur_idx_reg;
    logic [gbn_pkg::GEO_W-1:0]   cur_geo_reg;
    logic [gbn_pkg::SCORE_W-1:0] cur_score_reg;
    logic [gbn_pkg::CLASS_W-1:0] cur_class_reg;
    logic [31:0]                 cur_area_reg;

    logic [gbn_pkg::GEO_W-1:0]   pend_geo_reg;
    logic [gbn_pkg::SCORE_W-1:0] pend_score_reg;
    logic [gbn_pkg::CLASS_W-1:0] pend_class_reg;

    // Pair pipeline registers.
    logic          pv1_reg, pv2_reg, pv3_reg, pv4_reg, pv5_reg, pv6_reg;
    logic [IW-1:0] oth2_reg, oth3_reg, oth4_reg, oth5_reg, oth6_reg;
    logic          ok3_reg, ok4_reg, ok5_reg, ok6_reg;
    logic [CW-1:0] iw3_reg, ih3_reg, bw3_reg, bh3_reg;
    logic [31:0]   inter4_reg, barea4_reg, inter5_reg, inter6_reg;
    logic [32:0]   uni5_reg;
    logic [33:0]   plo6_reg;
    logic [32:0]   phi6_reg;

    logic [CW-1:0] al, at, aw, ah, bl, bt, bw, bh;
    logic [CW:0]   ar, ab, br, bb, lft, tp, rgt, btm;
    logic          ne;
    logic [50:0]   prod, lhs;
    logic          hit;
    logic          rank_gt;

    assign st_raddr = cmd.sel_order ? order_q : cmd.st_raddr;

    // Store writes and registered reads.
    always_ff @(posedge clk)
    begin
        if (cmd.load_we)
        begin
            geo_mem[cmd.st_waddr]   <= in_geo;
            score_mem[cmd.st_waddr] <= in_score;
            class_mem[cmd.st_waddr] <= in_class;
        end
        geo_q   <= geo_mem[st_raddr];
        score_q <= score_mem[st_raddr];
        class_q <= class_mem[st_raddr];
    end

    // Sorted order memory.
    always_ff @(posedge clk)
    begin
        if (cmd.ord_we)
        begin
            order_mem[rank_reg] <= cmd.outer_idx;
        end
        order_q <= order_mem[cmd.ord_raddr];
    end

    // Threshold register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= gbn_pkg::THR_RESET;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_data;
        end
    end

    // Rank counting: a stored score outranks the held one if it is higher, or
    // equal and earlier in arrival.
    assign rank_gt = (score_q > si_reg) || ((score_q == si_reg) && (jd_reg < cmd.outer_idx));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv1_reg <= 1'b0;
        end
        else
        begin
            rv1_reg <= cmd.rank_issue;
        end
    end

    always_ff @(posedge clk)
    begin
        jd_reg <= cmd.st_raddr;
        if (cmd.score_cap)
        begin
            si_reg <= score_q;
        end
        if (cmd.rank_clr)
        begin
            rank_reg <= '0;
        end
        else if (rv1_reg && rank_gt)
        begin
            rank_reg <= rank_reg + 1'b1;
        end
    end

    // Current box of the walk and the box waiting to be sent.
    always_ff @(posedge clk)
    begin
        if (cmd.idx_cap)
        begin
            cur_idx_reg <= order_q;
        end
        if (cmd.cur_cap)
        begin
            cur_geo_reg   <= geo_q;
            cur_score_reg <= score_q;
            cur_class_reg <= class_q;
        end
        cur_area_reg <= cur_geo_reg[2*CW +: CW] * cur_geo_reg[3*CW +: CW];
        if (cmd.pend_load)
        begin
            pend_geo_reg   <= cur_geo_reg;
            pend_score_reg <= cur_score_reg;
            pend_class_reg <= cur_class_reg;
        end
    end

    // Overlap geometry of the current box against a later one.
    always_comb
    begin
        al  = cur_geo_reg[0 +: CW];
        at  = cur_geo_reg[CW +: CW];
        aw  = cur_geo_reg[2*CW +: CW];
        ah  = cur_geo_reg[3*CW +: CW];
        bl  = geo_q[0 +: CW];
        bt  = geo_q[CW +: CW];
        bw  = geo_q[2*CW +: CW];
        bh  = geo_q[3*CW +: CW];
        ar  = {1'b0, al} + {1'b0, aw};
        ab  = {1'b0, at} + {1'b0, ah};
        br  = {1'b0, bl} + {1'b0, bw};
        bb  = {1'b0, bt} + {1'b0, bh};
        lft = (al > bl) ? {1'b0, al} : {1'b0, bl};
        tp  = (at > bt) ? {1'b0, at} : {1'b0, bt};
        rgt = (ar < br) ? ar : br;
        btm = (ab < bb) ? ab : bb;
        ne  = (rgt > lft) && (btm > tp);
    end

    // Final compare: intersection * 65536 against threshold * union.
    assign prod = {17'd0, plo6_reg} + {1'b0, phi6_reg, 17'd0};
    assign lhs  = {3'd0, inter6_reg, 16'd0};
    assign hit  = pv6_reg && ok6_reg && (lhs > prod);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv1_reg <= 1'b0;
            pv2_reg <= 1'b0;
            pv3_reg <= 1'b0;
            pv4_reg <= 1'b0;
            pv5_reg <= 1'b0;
            pv6_reg <= 1'b0;
        end
        else
        begin
            pv1_reg <= cmd.pair_issue;
            pv2_reg <= pv1_reg;
            pv3_reg <= pv2_reg;
            pv4_reg <= pv3_reg;
            pv5_reg <= pv4_reg;
            pv6_reg <= pv5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        oth2_reg   <= order_q;
        oth3_reg   <= oth2_reg;
        ok3_reg    <= ne && (class_q == cur_class_reg);
        iw3_reg    <= CW'(rgt - lft);
        ih3_reg    <= CW'(btm - tp);
        bw3_reg    <= bw;
        bh3_reg    <= bh;
        oth4_reg   <= oth3_reg;
        ok4_reg    <= ok3_reg;
        inter4_reg <= iw3_reg * ih3_reg;
        barea4_reg <= bw3_reg * bh3_reg;
        oth5_reg   <= oth4_reg;
        ok5_reg    <= ok4_reg;
        inter5_reg <= inter4_reg;
        uni5_reg   <= {1'b0, cur_area_reg} + {1'b0, barea4_reg} - {1'b0, inter4_reg};
        oth6_reg   <= oth5_reg;
        ok6_reg    <= ok5_reg;
        inter6_reg <= inter5_reg;
        plo6_reg   <= thr_reg * uni5_reg[16:0];
        phi6_reg   <= thr_reg * uni5_reg[32:17];
    end

    // Suppression marks, cleared at the end of each frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marks_reg <= '0;
        end
        else if (cmd.marks_clr)
        begin
            marks_reg <= '0;
        end
        else if (hit)
        begin
            marks_reg[oth6_reg] <= 1'b1;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (cmd.push)
        begin
            out_valid <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            out_geo   <= pend_geo_reg;
            out_score <= pend_score_reg;
            out_class <= pend_class_reg;
            out_last  <= cmd.push_last;
            out_ovf   <= cmd.push_ovf;
        end
    end

    assign stat.out_free   = !out_valid || out_ready;
    assign stat.pipe_busy  = rv1_reg || pv1_reg || pv2_reg || pv3_reg || pv4_reg
                             || pv5_reg || pv6_reg;
    assign stat.cur_marked = marks_reg[cur_idx_reg];

endmodule

`default_nettype wire

### design/gbn_ctrl.sv
`default_nettype none

module gbn_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_last,
    output logic                    in_ready,
    output gbn_pkg::gbn_cmd_t       cmd,
    input  wire gbn_pkg::gbn_stat_t stat
);

    localparam int IW = gbn_pkg::IDX_W;
    localparam int NW = gbn_pkg::CNT_W;
    localparam logic [NW-1:0] FULL = NW'(gbn_pkg::MAX_CAND);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b000000000001,
        S_RK_READ  = 12'b000000000010,
        S_RK_CAP   = 12'b000000000100,
        S_RK_SWEEP = 12'b000000001000,
        S_RK_DRAIN = 12'b000000010000,
        S_RK_WRITE = 12'b000000100000,
        S_WK_FETCH = 12'b000001000000,
        S_WK_SEL   = 12'b000010000000,
        S_WK_CAP   = 12'b000100000000,
        S_WK_CHECK = 12'b001000000000,
        S_WK_SWEEP = 12'b010000000000,
        S_FLUSH    = 12'b100000000000
    } state_t;

    state_t        state_reg, state_next;
    logic [NW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [NW-1:0] i_reg, i_next;
    logic [NW-1:0] j_reg, j_next;
    logic          pend_reg, pend_next;
    logic          drain_reg, drain_next;
    logic [NW-1:0] i_inc;

    assign i_inc = i_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            pend_reg  <= 1'b0;
            drain_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            pend_reg  <= pend_next;
            drain_reg <= drain_next;
        end
    end

    // Sequencer: load, rank every candidate, then walk the sorted order.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        pend_next  = pend_reg;
        drain_next = drain_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.st_waddr  = count_reg[IW-1:0];
        cmd.st_raddr  = j_reg[IW-1:0];
        cmd.ord_raddr = j_reg[IW-1:0];
        cmd.outer_idx = i_reg[IW-1:0];
        cmd.push_ovf  = ovf_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (count_reg < FULL)
                    begin
                        cmd.load_we = 1'b1;
                        count_next  = count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (in_last)
                    begin
                        i_next     = '0;
                        state_next = S_RK_READ;
                    end
                end
            end
            S_RK_READ:
            begin
                cmd.st_raddr = i_reg[IW-1:0];
                state_next   = S_RK_CAP;
            end
            S_RK_CAP:
            begin
                cmd.score_cap = 1'b1;
                cmd.rank_clr  = 1'b1;
                j_next        = '0;
                state_next    = S_RK_SWEEP;
            end
            S_RK_SWEEP:
            begin
                cmd.rank_issue = 1'b1;
                j_next         = j_reg + 1'b1;
                if (j_next == count_reg)
                begin
                    state_next = S_RK_DRAIN;
                end
            end
            S_RK_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = S_RK_WRITE;
                end
            end
            S_RK_WRITE:
            begin
                cmd.ord_we = 1'b1;
                i_next     = i_inc;
                if (i_inc == count_reg)
                begin
                    i_next     = '0;
                    state_next = S_WK_FETCH;
                end
                else
                begin
                    state_next = S_RK_READ;
                end
            end
            S_WK_FETCH:
            begin
                cmd.ord_raddr = i_reg[IW-1:0];
                state_next    = S_WK_SEL;
            end
            S_WK_SEL:
            begin
                cmd.sel_order = 1'b1;
                cmd.idx_cap   = 1'b1;
                state_next    = S_WK_CAP;
            end
            S_WK_CAP:
            begin
                cmd.cur_cap = 1'b1;
                state_next  = S_WK_CHECK;
            end
            S_WK_CHECK:
            begin
                // A kept box goes to the waiting slot; the one there before is
                // sent first, known now not to be the last.
                if (stat.cur_marked)
                begin
                    i_next     = i_inc;
                    state_next = (i_inc == count_reg) ? S_FLUSH : S_WK_FETCH;
                end
                else if (!pend_reg || stat.out_free)
                begin
                    cmd.push      = pend_reg;
                    cmd.pend_load = 1'b1;
                    pend_next     = 1'b1;
                    j_next        = i_inc;
                    drain_next    = 1'b0;
                    state_next    = (i_inc == count_reg) ? S_FLUSH : S_WK_SWEEP;
                end
            end
            S_WK_SWEEP:
            begin
                // The box stores are addressed by the registered order entry, so each
                // issued pair fetches its own box.
                cmd.sel_order = 1'b1;
                // Issue one later box a cycle, then wait for the marks to land.
                if (!drain_reg)
                begin
                    cmd.pair_issue = 1'b1;
                    j_next         = j_reg + 1'b1;
                    if (j_next == count_reg)
                    begin
                        drain_next = 1'b1;
                    end
                end
                else if (!stat.pipe_busy)
                begin
                    i_next     = i_inc;
                    state_next = (i_inc == count_reg) ? S_FLUSH : S_WK_FETCH;
                end
            end
            S_FLUSH:
            begin
                if (stat.out_free)
                begin
                    cmd.push      = 1'b1;
                    cmd.push_last = 1'b1;
                    cmd.marks_clr = 1'b1;
                    pend_next     = 1'b0;
                    count_next    = '0;
                    ovf_next      = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### design/greedy_box_nms.sv
// Greedy per-class box suppression.
// Input stream: one candidate box per word; tlast ends the frame. Words are
// taken at one per cycle while the block is loading; up to 64 are stored and
// any beyond that are dropped and reported on every result of the frame.
// After the last word the block ranks all n stored boxes by score (one score
// compare per cycle through the score store read port), then walks the ranked
// order. Each kept box is checked against every later box through a six-stage
// overlap pipeline, one pair per cycle. Input tready stays low from the last
// word until the final result of the frame enters the output register.
// Output stream: one word per kept box in descending score order, tlast on
// the final one, tuser set when candidates were dropped. A stalled receiver
// only holds the walk at the next kept box; the output register holds one word.
// Reset empties the stores' bookkeeping and sets the threshold to one half.
// The threshold may be written at any time the block is loading.
`default_nettype none

module greedy_box_nms (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [16:0] cfg_data,        // iou_threshold
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // box_left, box_top, box_width, box_height, box_score, box_class, pad
    input  wire logic [95:0] s_axis_tdata,
    input  wire logic        s_axis_tlast,    // last_candidate
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // kept_left, kept_top, kept_width, kept_height, kept_score, kept_class, pad
    output logic [95:0]      m_axis_tdata,
    output logic             m_axis_tlast,    // kept_last
    output logic             m_axis_tuser     // dropped_overflow
);

    gbn_pkg::gbn_cmd_t             cmd;
    gbn_pkg::gbn_stat_t            stat;
    logic [gbn_pkg::GEO_W-1:0]     out_geo;
    logic [gbn_pkg::SCORE_W-1:0]   out_score;
    logic [gbn_pkg::CLASS_W-1:0]   out_class;
    logic                          in_valid;

    assign in_valid = s_axis_tvalid && s_axis_tready;

    gbn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_last  (s_axis_tlast),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    gbn_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_geo    (s_axis_tdata[63:0]),
        .in_score  (s_axis_tdata[80:64]),
        .in_class  (s_axis_tdata[90:81]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_geo   (out_geo),
        .out_score (out_score),
        .out_class (out_class),
        .out_last  (m_axis_tlast),
        .out_ovf   (m_axis_tuser)
    );

    assign m_axis_tdata = {5'd0, out_class, out_score, out_geo};

    // A frame end must stop intake until its results are resolved.
    a_stop_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && s_axis_tlast |=> !s_axis_tready)
        else $error("input taken right after frame end");

    // A result that is not the frame's last means the walk is still running.
    a_walk_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input open during the suppression walk");

    // Nothing is stored while the walk is running.
    a_no_load_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_we |-> s_axis_tready && s_axis_tvalid)
        else $error("store written outside loading");

endmodule

`default_nettype wire
